// File: src/sgci_pkg.sv
// shared types, constants and saturating helpers for the small/great circle intersector
package sgci_pkg;

   localparam int FRAC_BITS_DEF = 30;
   localparam int MUL_LAT       = 4;
   localparam int TOL_W         = 20;
   localparam logic [TOL_W-1:0] TOL_RESET = 20'd1074;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   typedef logic signed [63:0] val_type;

   localparam val_type SATV = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [65:0] SATV_WIDE = 66'sh0_3FFF_FFFF_FFFF_FFFF;
   localparam val_type I32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam val_type I32_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic signed [31:0] small_axis_x;
      logic signed [31:0] small_axis_y;
      logic signed [31:0] small_axis_z;
      logic signed [31:0] cos_colatitude;
      logic signed [31:0] great_axis_x;
      logic signed [31:0] great_axis_y;
      logic signed [31:0] great_axis_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         point_count;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
   } rsp_type;

   // pipeline depth of the divider and the square root
   function automatic int div_lat(input int fb);
      return fb + 65;
   endfunction

   function automatic int sqrt_lat(input int fb);
      return (fb + 63) / 2;
   endfunction

   function automatic val_type sat_fn(input logic signed [65:0] v);
      if (v > SATV_WIDE) return SATV;
      else if (v < -SATV_WIDE) return -SATV;
      else return val_type'(v[63:0]);
   endfunction

   function automatic val_type sat_add(input val_type a, input val_type b);
      logic signed [65:0] s;
      s = 66'(a) + 66'(b);
      return sat_fn(s);
   endfunction

   function automatic val_type sat_sub(input val_type a, input val_type b);
      logic signed [65:0] s;
      s = 66'(a) - 66'(b);
      return sat_fn(s);
   endfunction

   function automatic logic signed [31:0] clamp32(input val_type v);
      if (v > I32_MAX) return 32'sh7FFF_FFFF;
      else if (v < I32_MIN) return 32'sh8000_0000;
      else return v[31:0];
   endfunction

endpackage

// File: src/sgci_delay.sv
// enabled shift line that keeps operands aligned with the pipeline
module sgci_delay #(
   parameter int W = 64,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] sr_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign q = sr_ff[N-1];
endmodule

// File: src/sgci_mul.sv
// four stage fixed point multiplier, rounded half away from zero and saturated
module sgci_mul #(
   parameter int FRAC_BITS = sgci_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  sgci_pkg::val_type a,
   input  sgci_pkg::val_type b,
   output sgci_pkg::val_type p
);
   import sgci_pkg::*;

   localparam int PW = 126;
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   val_type        a_abs, b_abs;
   logic           neg1_ff, neg2_ff, neg3_ff;
   logic [62:0]    am_ff, bm_ff;
   logic [63:0]    p00_ff;
   logic [62:0]    p01_ff, p10_ff;
   logic [61:0]    p11_ff;
   logic [PW-1:0]  sum_in, sum_ff, shr;
   val_type        mag_in, p_ff;

   assign a_abs = a[63] ? -a : a;
   assign b_abs = b[63] ? -b : b;

   always_comb begin
      sum_in = (PW'(p11_ff) << 64) + (PW'(p01_ff) << 32) + (PW'(p10_ff) << 32)
             + PW'(p00_ff) + HALF;
      shr    = sum_ff >> FRAC_BITS;
      mag_in = (|shr[PW-1:62]) ? SATV : val_type'(shr[63:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= a[63] ^ b[63];
         am_ff   <= a_abs[62:0];
         bm_ff   <= b_abs[62:0];
         neg2_ff <= neg1_ff;
         p00_ff  <= 64'(am_ff[31:0] * bm_ff[31:0]);
         p01_ff  <= 63'(am_ff[31:0] * bm_ff[62:32]);
         p10_ff  <= 63'(am_ff[62:32] * bm_ff[31:0]);
         p11_ff  <= 62'(am_ff[62:32] * bm_ff[62:32]);
         neg3_ff <= neg2_ff;
         sum_ff  <= sum_in;
         p_ff    <= neg3_ff ? -mag_in : mag_in;
      end
   end

   assign p = p_ff;
endmodule

// File: src/sgci_div.sv
// pipelined restoring divider, one quotient bit a stage, rounded and saturated
module sgci_div #(
   parameter int FRAC_BITS = sgci_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  sgci_pkg::val_type n,
   input  sgci_pkg::val_type d,
   output sgci_pkg::val_type q
);
   import sgci_pkg::*;

   localparam int NB = FRAC_BITS + 63;
   localparam int DW = 62;

   val_type        n_abs, d_abs;
   logic [NB-1:0]  num0_ff;
   logic [DW-1:0]  ud0_ff;
   logic           neg0_ff;

   logic [DW-1:0]  rem_c [NB];
   logic [NB-1:0]  num_c [NB];
   logic [63:0]    q_c   [NB];
   logic           ovf_c [NB];
   logic [DW-1:0]  ud_c  [NB];
   logic           neg_c [NB];
   logic [DW:0]    t_c   [NB];
   logic           ge_c  [NB];

   logic [DW-1:0]  rem_in [NB];
   logic [63:0]    q_in   [NB];
   logic           ovf_in [NB];

   logic [DW-1:0]  rem_ff [NB];
   logic [NB-1:0]  num_ff [NB];
   logic [63:0]    q_ff   [NB];
   logic           ovf_ff [NB];
   logic [DW-1:0]  ud_ff  [NB];
   logic           neg_ff [NB];

   logic [63:0]    rnd;
   val_type        mag_out, q_out_ff;

   assign n_abs = n[63] ? -n : n;
   assign d_abs = d[63] ? -d : d;

   always_comb begin
      for (int i = 0; i < NB; i++) begin
         if (i == 0) begin
            rem_c[i] = '0;
            num_c[i] = num0_ff;
            q_c[i]   = '0;
            ovf_c[i] = 1'b0;
            ud_c[i]  = ud0_ff;
            neg_c[i] = neg0_ff;
         end else begin
            rem_c[i] = rem_ff[i-1];
            num_c[i] = num_ff[i-1];
            q_c[i]   = q_ff[i-1];
            ovf_c[i] = ovf_ff[i-1];
            ud_c[i]  = ud_ff[i-1];
            neg_c[i] = neg_ff[i-1];
         end
         t_c[i]    = {rem_c[i], num_c[i][NB-1]};
         ge_c[i]   = t_c[i] >= {1'b0, ud_c[i]};
         rem_in[i] = ge_c[i] ? DW'(t_c[i] - {1'b0, ud_c[i]}) : t_c[i][DW-1:0];
         q_in[i]   = {q_c[i][62:0], ge_c[i]};
         // a quotient of 2^63 or more saturates
         ovf_in[i] = ovf_c[i] | q_in[i][63];
      end
   end

   always_comb begin
      rnd     = (q_ff[NB-1] + 64'd1) >> 1;
      mag_out = (ovf_ff[NB-1] || rnd[63:62] != 2'b00) ? SATV : val_type'(rnd);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num0_ff <= {n_abs[DW-1:0], {(FRAC_BITS+1){1'b0}}};
         ud0_ff  <= d_abs[DW-1:0];
         neg0_ff <= n[63] ^ d[63];
         for (int i = 0; i < NB; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_c[i] << 1;
            q_ff[i]   <= q_in[i];
            ovf_ff[i] <= ovf_in[i];
            ud_ff[i]  <= ud_c[i];
            neg_ff[i] <= neg_c[i];
         end
         q_out_ff <= neg_ff[NB-1] ? -mag_out : mag_out;
      end
   end

   assign q = q_out_ff;
endmodule

// File: src/sgci_sqrt.sv
// pipelined integer square root, one result bit a stage, truncated
module sgci_sqrt #(
   parameter int FRAC_BITS = sgci_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             en,
   input  sgci_pkg::val_type d,
   output sgci_pkg::val_type r
);
   import sgci_pkg::*;

   localparam int RB = sqrt_lat(FRAC_BITS);
   localparam int VB = 2 * RB;
   localparam int RW = RB + 2;

   val_type        d_abs;
   logic [VB-1:0]  v0;

   logic [RW-1:0]  rem_c  [RB];
   logic [RB-1:0]  root_c [RB];
   logic [VB-1:0]  v_c    [RB];
   logic [RW+1:0]  t_c    [RB];
   logic [RW+1:0]  trial_c[RB];
   logic           ge_c   [RB];

   logic [RW-1:0]  rem_ff  [RB];
   logic [RB-1:0]  root_ff [RB];
   logic [VB-1:0]  v_ff    [RB];

   assign d_abs = d[63] ? -d : d;
   assign v0    = VB'({d_abs[61:0], {FRAC_BITS{1'b0}}});

   always_comb begin
      for (int i = 0; i < RB; i++) begin
         if (i == 0) begin
            rem_c[i]  = '0;
            root_c[i] = '0;
            v_c[i]    = v0;
         end else begin
            rem_c[i]  = rem_ff[i-1];
            root_c[i] = root_ff[i-1];
            v_c[i]    = v_ff[i-1];
         end
         // bring down two radicand bits, try root*4+1
         t_c[i]     = {rem_c[i], v_c[i][VB-1:VB-2]};
         trial_c[i] = (RW+2)'({root_c[i], 2'b01});
         ge_c[i]    = t_c[i] >= trial_c[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < RB; i++) begin
            rem_ff[i]  <= ge_c[i] ? RW'(t_c[i] - trial_c[i]) : RW'(t_c[i]);
            root_ff[i] <= {root_c[i][RB-2:0], ge_c[i]};
            v_ff[i]    <= v_c[i] << 2;
         end
      end
   end

   assign r = val_type'(64'(root_ff[RB-1]));
endmodule

// File: src/small_great_circle_intersect.sv
// top level of the small circle / great circle intersection pipeline
//
// req_ carries one query: small circle axis, cosine of its colatitude and
// great circle axis, all signed Q1.30. rsp_ carries the answer: the point
// count (0, 1 or 2) and up to two points, minus root first; unused points
// read as zero. Both channels are valid/ready; a beat moves when both are high.
// csr_wr_en/csr_wr_data write the 20-bit tolerance used by the collinearity
// and tangency tests; write it only while the pipeline is empty.
// One query can enter every cycle while no result is held off. The pipeline
// depth is set mainly by the two serial dividers of FRAC_BITS+65 stages each
// and the square root of (FRAC_BITS+63)/2 stages. When the receiver holds off
// a waiting result the whole pipeline freezes in place and req_ready drops;
// nothing is lost or repeated. Reset empties the pipeline and sets the
// tolerance to 1074.
module small_great_circle_intersect #(
   parameter int FRAC_BITS = sgci_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sgci_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sgci_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [sgci_pkg::TOL_W-1:0]   csr_wr_data
);
   import sgci_pkg::*;

   localparam int M   = MUL_LAT;
   localparam int D   = div_lat(FRAC_BITS);
   localparam int SQ  = sqrt_lat(FRAC_BITS);
   localparam int T2  = M + 1;
   localparam int T3  = T2 + M + 1;
   localparam int T4  = T3 + D;
   localparam int T5  = T4 + M;
   localparam int T6  = T5 + M + 2;
   localparam int T7  = T6 + M + 1;
   localparam int T8  = T7 + SQ;
   localparam int T9  = T8 + 1;
   localparam int T10 = T9 + D;
   localparam int LAT = T10 + M + 1;
   localparam val_type ONE = val_type'(64'd1 << FRAC_BITS);

   logic               adv;
   logic [LAT-1:0]     vld_ff;
   logic [TOL_W-1:0]   tol_ff;
   val_type            tol_v;

   val_type s [3];
   val_type g [3];
   val_type cosv;

   val_type a_a [6], a_b [6], a_p [6];
   val_type c_a [6], c_b [6], c_p [6];
   val_type e_a [6], e_b [6], e_p [6];
   val_type i_a [6], i_b [6], i_p [6];
   val_type b_p [3];
   val_type av [3];
   val_type f_mc, f_bb;

   val_type g_d [3];
   val_type bv_ff [3], cg_ff [3];
   val_type bv_d5 [3], bv_d10 [3], cg_d [3], av_d [3];
   val_type m_ff, m_d6, m_d7, cos_d, scale;
   val_type e1b_ff, e2b_ff, e1c_ff, e2c_ff, b_ff, cc_ff, b_d8;
   val_type disc_ff, den_ff, den_d9, pm, n1_ff, n2_ff, t1, t2;
   logic [1:0] cnt_ff, cnt_d8, cnt_end;
   logic [1:0] cnt_in;
   logic signed [31:0] pt1 [3], pt2 [3];
   rsp_type    rsp_ff;

   assign rsp_valid = vld_ff[LAT-1];
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign rsp_data  = rsp_ff;
   assign tol_v     = val_type'(tol_ff);

   assign s[0] = val_type'(req_data.small_axis_x);
   assign s[1] = val_type'(req_data.small_axis_y);
   assign s[2] = val_type'(req_data.small_axis_z);
   assign g[0] = val_type'(req_data.great_axis_x);
   assign g[1] = val_type'(req_data.great_axis_y);
   assign g[2] = val_type'(req_data.great_axis_z);
   assign cosv = val_type'(req_data.cos_colatitude);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         tol_ff <= TOL_RESET;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_valid};
         end
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
   end

   // B = G x S
   assign a_a[0] = g[1]; assign a_b[0] = s[2];
   assign a_a[1] = g[2]; assign a_b[1] = s[1];
   assign a_a[2] = g[2]; assign a_b[2] = s[0];
   assign a_a[3] = g[0]; assign a_b[3] = s[2];
   assign a_a[4] = g[0]; assign a_b[4] = s[1];
   assign a_a[5] = g[1]; assign a_b[5] = s[0];

   // B x G, for the point A on the line of intersection
   assign c_a[0] = bv_ff[1]; assign c_b[0] = g_d[2];
   assign c_a[1] = bv_ff[2]; assign c_b[1] = g_d[1];
   assign c_a[2] = bv_ff[2]; assign c_b[2] = g_d[0];
   assign c_a[3] = bv_ff[0]; assign c_b[3] = g_d[2];
   assign c_a[4] = bv_ff[0]; assign c_b[4] = g_d[1];
   assign c_a[5] = bv_ff[1]; assign c_b[5] = g_d[0];

   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_lane
         sgci_delay #(.W(64), .N(T2)) u_dly_g (
            .clock, .en(adv), .d(g[k]), .q(g_d[k]));
         sgci_delay #(.W(64), .N(D)) u_dly_cg (
            .clock, .en(adv), .d(cg_ff[k]), .q(cg_d[k]));
         sgci_delay #(.W(64), .N(T5 - T2)) u_dly_bv5 (
            .clock, .en(adv), .d(bv_ff[k]), .q(bv_d5[k]));
         sgci_delay #(.W(64), .N(T10 - T5)) u_dly_bv10 (
            .clock, .en(adv), .d(bv_d5[k]), .q(bv_d10[k]));
         sgci_delay #(.W(64), .N(T10 + M - T5)) u_dly_av (
            .clock, .en(adv), .d(av[k]), .q(av_d[k]));

         sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_m (
            .clock, .en(adv), .a(bv_ff[k]), .b(bv_ff[k]), .p(b_p[k]));
         sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_av (
            .clock, .en(adv), .a(cg_d[k]), .b(scale), .p(av[k]));

         assign e_a[k]   = av[k];
         assign e_b[k]   = bv_d5[k];
         assign e_a[k+3] = av[k];
         assign e_b[k+3] = av[k];
         assign i_a[k]   = bv_d10[k];
         assign i_b[k]   = t1;
         assign i_a[k+3] = bv_d10[k];
         assign i_b[k+3] = t2;
      end

      for (k = 0; k < 6; k++) begin : g_mul6
         sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
            .clock, .en(adv), .a(a_a[k]), .b(a_b[k]), .p(a_p[k]));
         sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_c (
            .clock, .en(adv), .a(c_a[k]), .b(c_b[k]), .p(c_p[k]));
         sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
            .clock, .en(adv), .a(e_a[k]), .b(e_b[k]), .p(e_p[k]));
         sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_i (
            .clock, .en(adv), .a(i_a[k]), .b(i_b[k]), .p(i_p[k]));
      end
   endgenerate

   sgci_delay #(.W(64), .N(T3)) u_dly_cos (
      .clock, .en(adv), .d(cosv), .q(cos_d));
   sgci_delay #(.W(64), .N(T6 - T3)) u_dly_m6 (
      .clock, .en(adv), .d(m_ff), .q(m_d6));
   sgci_delay #(.W(64), .N(T7 - T6)) u_dly_m7 (
      .clock, .en(adv), .d(m_d6), .q(m_d7));
   sgci_delay #(.W(64), .N(T8 - T6)) u_dly_b8 (
      .clock, .en(adv), .d(b_ff), .q(b_d8));
   sgci_delay #(.W(2), .N(T8 - T7 - 1)) u_dly_cnt8 (
      .clock, .en(adv), .d(cnt_ff), .q(cnt_d8));
   sgci_delay #(.W(2), .N(T10 + M - T8)) u_dly_cnt_end (
      .clock, .en(adv), .d(cnt_d8), .q(cnt_end));
   sgci_delay #(.W(64), .N(T9 - T7 - 1)) u_dly_den (
      .clock, .en(adv), .d(den_ff), .q(den_d9));

   sgci_div #(.FRAC_BITS(FRAC_BITS)) u_div_scale (
      .clock, .en(adv), .n(cos_d), .d(m_ff), .q(scale));

   sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_mc (
      .clock, .en(adv), .a(m_d6), .b(cc_ff), .p(f_mc));
   sgci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_bb (
      .clock, .en(adv), .a(b_ff), .b(b_ff), .p(f_bb));

   sgci_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock, .en(adv), .d(disc_ff), .r(pm));

   sgci_div #(.FRAC_BITS(FRAC_BITS)) u_div_t1 (
      .clock, .en(adv), .n(n1_ff), .d(den_d9), .q(t1));
   sgci_div #(.FRAC_BITS(FRAC_BITS)) u_div_t2 (
      .clock, .en(adv), .n(n2_ff), .d(den_d9), .q(t2));

   always_comb begin
      priority if (m_d7 <= tol_v) cnt_in = CNT_NONE;
      else if (disc_ff < -tol_v)  cnt_in = CNT_NONE;
      else if (disc_ff <= tol_v)  cnt_in = CNT_ONE;
      else                        cnt_in = CNT_TWO;
      for (int j = 0; j < 3; j++) begin
         pt1[j] = clamp32(sat_add(av_d[j], i_p[j]));
         pt2[j] = clamp32(sat_add(av_d[j], i_p[j+3]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            bv_ff[j] <= sat_sub(a_p[2*j], a_p[2*j+1]);
            cg_ff[j] <= sat_sub(c_p[2*j], c_p[2*j+1]);
         end
         m_ff    <= sat_add(sat_add(b_p[0], b_p[1]), b_p[2]);
         // A.B and A.A over two stages
         e1b_ff  <= sat_add(e_p[0], e_p[1]);
         e2b_ff  <= e_p[2];
         e1c_ff  <= sat_add(e_p[3], e_p[4]);
         e2c_ff  <= e_p[5];
         b_ff    <= sat_add(sat_add(e1b_ff, e2b_ff), sat_add(e1b_ff, e2b_ff));
         cc_ff   <= sat_sub(sat_add(e1c_ff, e2c_ff), ONE);
         // b^2 - 4 a c, the doublings saturate like one shift by two
         disc_ff <= sat_sub(f_bb, sat_fn(66'(f_mc) <<< 2));
         cnt_ff  <= cnt_in;
         den_ff  <= sat_add(m_d7, m_d7);
         n1_ff   <= (cnt_d8 == CNT_ONE) ? -b_d8 : sat_sub(-b_d8, pm);
         n2_ff   <= sat_add(-b_d8, pm);
         rsp_ff.point_count <= cnt_end;
         rsp_ff.first_x  <= (cnt_end != CNT_NONE) ? pt1[0] : 32'sd0;
         rsp_ff.first_y  <= (cnt_end != CNT_NONE) ? pt1[1] : 32'sd0;
         rsp_ff.first_z  <= (cnt_end != CNT_NONE) ? pt1[2] : 32'sd0;
         rsp_ff.second_x <= (cnt_end == CNT_TWO) ? pt2[0] : 32'sd0;
         rsp_ff.second_y <= (cnt_end == CNT_TWO) ? pt2[1] : 32'sd0;
         rsp_ff.second_z <= (cnt_end == CNT_TWO) ? pt2[2] : 32'sd0;
      end
   end

   a_second_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.point_count != CNT_TWO |->
         rsp_data.second_x == 0 && rsp_data.second_y == 0 && rsp_data.second_z == 0)
      else $error("second point not blank");

   a_ready_only_on_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input held off without an output hold");

   a_frozen_on_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vld_ff))
      else $error("pipeline moved while output held");

endmodule
